// ===== design/lfr_pkg.sv =====
package lfr_pkg;

    localparam int BYTE_W = 8;
    localparam int SEQ_W = 32;
    localparam int EVENT_W = 3;
    localparam int SLOT_IDX_W = 3;
    localparam int WORD_IDX_W = 9;
    localparam int LANE_W = 2;
    localparam int FLEN_OUT_W = 9;
    localparam int COUNT_W = 32;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_END = 8'h5A;

    typedef enum logic [EVENT_W-1:0] {
        EV_STORED = 3'd0,
        EV_PUBLISHED = 3'd1,
        EV_BAD = 3'd2,
        EV_OVERFLOW = 3'd3,
        EV_TOO_LONG = 3'd4,
        EV_IGNORED = 3'd5,
        EV_READ = 3'd6
    } lfr_event_t;

    typedef enum logic {
        FUNC_BYTE = 1'b0,
        FUNC_READ = 1'b1
    } lfr_func_t;

    typedef struct packed {
        logic func;
        logic [BYTE_W-1:0] rx_byte;
        logic [SEQ_W-1:0] consumer_read_seq;
    } lfr_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [WORD_IDX_W-1:0] word_addr;
        logic [LANE_W-1:0] byte_lane;
        logic [BYTE_W-1:0] data_byte;
        logic [FLEN_OUT_W-1:0] frame_length;
        logic [COUNT_W-1:0] commands_count;
        logic [COUNT_W-1:0] overflow_count;
        logic [COUNT_W-1:0] too_long_count;
        logic [COUNT_W-1:0] bad_frame_count;
    } lfr_result_t;

endpackage

// ===== design/lfr_in_if.sv =====
interface lfr_in_if
    import lfr_pkg::*;
;
    logic valid;
    logic ready;
    logic func;
    logic [BYTE_W-1:0] rx_byte;
    logic [SEQ_W-1:0] consumer_read_seq;

    modport source (output valid, output func, output rx_byte, output consumer_read_seq,
                    input ready);
    modport sink (input valid, input func, input rx_byte, input consumer_read_seq,
                  output ready);
endinterface

// ===== design/lfr_out_if.sv =====
interface lfr_out_if
    import lfr_pkg::*;
;
    logic valid;
    logic ready;
    logic [EVENT_W-1:0] event_res;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [WORD_IDX_W-1:0] word_addr;
    logic [LANE_W-1:0] byte_lane;
    logic [BYTE_W-1:0] data_byte;
    logic [FLEN_OUT_W-1:0] frame_length;
    logic [COUNT_W-1:0] commands_count;
    logic [COUNT_W-1:0] overflow_count;
    logic [COUNT_W-1:0] too_long_count;
    logic [COUNT_W-1:0] bad_frame_count;

    modport source (output valid, output event_res, output slot_index, output word_addr,
                    output byte_lane, output data_byte, output frame_length,
                    output commands_count, output overflow_count, output too_long_count,
                    output bad_frame_count, input ready);
    modport sink (input valid, input event_res, input slot_index, input word_addr,
                  input byte_lane, input data_byte, input frame_length,
                  input commands_count, input overflow_count, input too_long_count,
                  input bad_frame_count, output ready);
endinterface

// ===== design/lfr_framer.sv =====
module lfr_framer
    import lfr_pkg::*;
#(
    parameter int RING_SLOTS = 8,
    parameter int MAX_FRAME_BYTES = 256,
    parameter int WORDS_PER_SLOT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  lfr_item_t   item,
    output lfr_result_t res
);

    localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int FLEN_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [SEQ_W-1:0]   write_seq_reg, write_seq_next;
    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [SEQ_W-1:0]   read_seq_reg, read_seq_next;
    logic [FLEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [SLOT_W-1:0]  active_slot_reg, active_slot_next;
    logic [BYTE_W-1:0]  prev_byte_reg, prev_byte_next;
    logic               discarding_reg, discarding_next;
    logic [COUNT_W-1:0] pub_total_reg, pub_total_next;
    logic [COUNT_W-1:0] ovf_total_reg, ovf_total_next;
    logic [COUNT_W-1:0] long_total_reg, long_total_next;
    logic [COUNT_W-1:0] bad_total_reg, bad_total_next;

    lfr_event_t         ev;
    logic [SEQ_W-1:0]   used;
    logic [SLOT_W-1:0]  slot_cur;
    logic [31:0]        word_full;
    logic               blocked;

    assign used = write_seq_reg - read_seq_reg;
    assign word_full = 32'(slot_cur) * 32'(WORDS_PER_SLOT) + (32'(frame_len_reg) >> 2);

    always_comb
    begin
        write_seq_next = write_seq_reg;
        write_slot_next = write_slot_reg;
        read_seq_next = read_seq_reg;
        frame_len_next = frame_len_reg;
        active_slot_next = active_slot_reg;
        prev_byte_next = prev_byte_reg;
        discarding_next = discarding_reg;
        pub_total_next = pub_total_reg;
        ovf_total_next = ovf_total_reg;
        long_total_next = long_total_reg;
        bad_total_next = bad_total_reg;
        ev = EV_IGNORED;
        slot_cur = active_slot_reg;
        blocked = 1'b0;
        res = '0;

        if (item.func == FUNC_READ)
        begin
            read_seq_next = item.consumer_read_seq;
            ev = EV_READ;
        end
        else if (item.rx_byte == CH_CR)
        begin
            ev = EV_IGNORED;
        end
        else if (item.rx_byte == CH_LF)
        begin
            if (!discarding_reg && frame_len_reg != '0)
            begin
                if (prev_byte_reg == CH_END)
                begin
                    res.frame_length = FLEN_OUT_W'(frame_len_reg);
                    write_seq_next = write_seq_reg + 1'b1;
                    if (write_slot_reg == SLOT_W'(RING_SLOTS - 1))
                    begin
                        write_slot_next = '0;
                    end
                    else
                    begin
                        write_slot_next = write_slot_reg + 1'b1;
                    end
                    pub_total_next = pub_total_reg + 1'b1;
                    ev = EV_PUBLISHED;
                end
                else
                begin
                    bad_total_next = bad_total_reg + 1'b1;
                    ev = EV_BAD;
                end
            end
            frame_len_next = '0;
            prev_byte_next = '0;
            discarding_next = 1'b0;
        end
        else
        begin
            // first byte of a frame reserves a slot, or counts an overflow if the ring is full
            if (frame_len_reg == '0 && !discarding_reg)
            begin
                if (used >= SEQ_W'(RING_SLOTS))
                begin
                    ovf_total_next = ovf_total_reg + 1'b1;
                    discarding_next = 1'b1;
                    ev = EV_OVERFLOW;
                    blocked = 1'b1;
                end
                else
                begin
                    slot_cur = write_slot_reg;
                    active_slot_next = write_slot_reg;
                end
            end
            if (!blocked)
            begin
                if (discarding_reg)
                begin
                    ev = EV_IGNORED;
                end
                else if (frame_len_reg >= FLEN_W'(MAX_FRAME_BYTES))
                begin
                    long_total_next = long_total_reg + 1'b1;
                    discarding_next = 1'b1;
                    ev = EV_TOO_LONG;
                end
                else
                begin
                    res.word_addr = word_full[WORD_IDX_W-1:0];
                    res.byte_lane = LANE_W'(frame_len_reg);
                    res.data_byte = item.rx_byte;
                    frame_len_next = frame_len_reg + 1'b1;
                    prev_byte_next = item.rx_byte;
                    ev = EV_STORED;
                end
            end
        end

        res.event_res = ev;
        res.slot_index = SLOT_IDX_W'(active_slot_next);
        res.commands_count = pub_total_next;
        res.overflow_count = ovf_total_next;
        res.too_long_count = long_total_next;
        res.bad_frame_count = bad_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_seq_reg <= '0;
            write_slot_reg <= '0;
            read_seq_reg <= '0;
            frame_len_reg <= '0;
            active_slot_reg <= '0;
            prev_byte_reg <= '0;
            discarding_reg <= 1'b0;
            pub_total_reg <= '0;
            ovf_total_reg <= '0;
            long_total_reg <= '0;
            bad_total_reg <= '0;
        end
        else if (step)
        begin
            write_seq_reg <= write_seq_next;
            write_slot_reg <= write_slot_next;
            read_seq_reg <= read_seq_next;
            frame_len_reg <= frame_len_next;
            active_slot_reg <= active_slot_next;
            prev_byte_reg <= prev_byte_next;
            discarding_reg <= discarding_next;
            pub_total_reg <= pub_total_next;
            ovf_total_reg <= ovf_total_next;
            long_total_reg <= long_total_next;
            bad_total_reg <= bad_total_next;
        end
    end

endmodule

// ===== design/line_frame_ring_receiver.sv =====
// path: an accepted item goes to the input register, and its result to the result register that drives out_ch
// throughput: one item per cycle, set by the input and result registers
// each handing on whenever the stage after it is free
// reset: rst_n clears all frame state, sequences and totals to zero
// and empties both pipeline stages
module line_frame_ring_receiver
    import lfr_pkg::*;
#(
    parameter int RING_SLOTS = 8,
    parameter int MAX_FRAME_BYTES = 256,
    parameter int WORDS_PER_SLOT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lfr_in_if.sink     in_ch,
    lfr_out_if.source  out_ch
);

    logic        s1_valid_reg;
    lfr_item_t   s1_item_reg;
    logic        out_valid_reg;
    lfr_result_t out_res_reg;
    lfr_result_t step_res;
    logic        out_free;
    logic        s1_move;
    logic        in_take;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign s1_move = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_take = in_ch.valid && in_ch.ready;

    lfr_framer #(
        .RING_SLOTS(RING_SLOTS),
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .WORDS_PER_SLOT(WORDS_PER_SLOT)
    ) u_framer (
        .clk(clk),
        .rst_n(rst_n),
        .step(s1_move),
        .item(s1_item_reg),
        .res(step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.func <= in_ch.func;
            s1_item_reg.rx_byte <= in_ch.rx_byte;
            s1_item_reg.consumer_read_seq <= in_ch.consumer_read_seq;
        end
        if (s1_move)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.event_res = out_res_reg.event_res;
    assign out_ch.slot_index = out_res_reg.slot_index;
    assign out_ch.word_addr = out_res_reg.word_addr;
    assign out_ch.byte_lane = out_res_reg.byte_lane;
    assign out_ch.data_byte = out_res_reg.data_byte;
    assign out_ch.frame_length = out_res_reg.frame_length;
    assign out_ch.commands_count = out_res_reg.commands_count;
    assign out_ch.overflow_count = out_res_reg.overflow_count;
    assign out_ch.too_long_count = out_res_reg.too_long_count;
    assign out_ch.bad_frame_count = out_res_reg.bad_frame_count;

endmodule
